// ===== rtl/ctb_pkg.sv =====
package ctb_pkg;

    localparam int SLOT_COUNT  = 16;
    localparam int COUNT_WIDTH = 24;

    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int MASK_W     = 16;
    localparam int VIS_SLOTS  = (SLOT_COUNT < MASK_W) ? SLOT_COUNT : MASK_W;
    localparam int MODE_W     = 2;
    localparam int DELAY_W    = 24;
    localparam int ACK_W      = 4;
    localparam int OUT_SLOT_W = 4;
    localparam int MS_W       = 10;
    localparam int TPS_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;
    localparam int DIV_CNT_W  = $clog2(DELAY_W);
    localparam int CALC_W     = (COUNT_WIDTH > DELAY_W) ? COUNT_WIDTH : DELAY_W;

    localparam logic [MS_W-1:0]   MS_RESET  = MS_W'(55);
    localparam logic [TPS_W-1:0]  TPS_RESET = TPS_W'(1);
    localparam logic [CALC_W-1:0] COUNT_MAX =
        CALC_W'((64'd1 << COUNT_WIDTH) - 64'd1);

    localparam logic [CFG_IDX_W-1:0] CFG_MS_PER_TICK      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SWITCH = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK    = 2'd0,
        MODE_REQUEST = 2'd1,
        MODE_ACK     = 2'd2,
        MODE_NONE    = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK_RD,
        S_TICK_WR,
        S_DIV,
        S_RESP
    } t_state;

    typedef logic [COUNT_WIDTH-1:0] t_count;

endpackage

// ===== rtl/countdown_timer_bank_unit.sv =====
// Bank of countdown timers with one command port. An item is taken when start
// is high and busy is low; exactly one result follows, shown for one cycle
// with o_result_valid high, and it cannot be held off, so capture it on that
// cycle. A tick walks the slot memory one slot at a time, a read state and a
// write-back state per slot, then the result state. A request runs the serial
// divider, one quotient bit per cycle, then loads the first free slot (or is
// refused, or done at once if the count rounds to zero) and shows its result.
// An acknowledge or an unused mode shows its result in the cycle right after
// the transfer. busy stays high from the transfer of a command until its
// result cycle has passed. Configuration writes are always ready and take
// effect at once; write them only while busy is low.
module countdown_timer_bank_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command channel
    input  logic                              start,
    output logic                              busy,
    input  logic [ctb_pkg::MODE_W-1:0]        i_mode,
    input  logic [ctb_pkg::DELAY_W-1:0]       i_delay_ms,
    input  logic [ctb_pkg::ACK_W-1:0]         i_ack_slot,
    // configuration channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ctb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ctb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // result
    output logic                              o_result_valid,
    output logic                              o_granted,
    output logic [ctb_pkg::OUT_SLOT_W-1:0]    o_granted_slot,
    output logic                              o_refused,
    output logic                              o_done_at_once,
    output logic [ctb_pkg::MASK_W-1:0]        o_expired_now,
    output logic [ctb_pkg::MASK_W-1:0]        o_pending_done,
    output logic                              o_switch_due
);

    // control state
    ctb_pkg::t_state                    r_state, n_state;
    logic [ctb_pkg::SLOT_W-1:0]         r_idx, n_idx;
    logic [ctb_pkg::SLOT_COUNT-1:0]     r_busy, n_busy;   // count is nonzero
    logic [ctb_pkg::SLOT_COUNT-1:0]     r_done, n_done;   // done flag pending
    logic [ctb_pkg::TPS_W-1:0]          r_sw_cnt, n_sw_cnt;
    logic [ctb_pkg::MS_W-1:0]           r_ms, n_ms;
    logic [ctb_pkg::TPS_W-1:0]          r_tps, n_tps;

    // result fields
    logic                               r_granted, n_granted;
    logic [ctb_pkg::SLOT_W-1:0]         r_gslot, n_gslot;
    logic                               r_refused, n_refused;
    logic                               r_at_once, n_at_once;
    logic [ctb_pkg::MASK_W-1:0]         r_expired, n_expired;
    logic                               r_sw, n_sw;

    // slot count memory; only slots whose busy bit is set hold a live count
    ctb_pkg::t_count                    mem [ctb_pkg::SLOT_COUNT];
    ctb_pkg::t_count                    r_rd_data;
    logic                               w_mem_we;
    logic [ctb_pkg::SLOT_W-1:0]         w_mem_waddr;
    ctb_pkg::t_count                    w_mem_wdata;

    // divider
    logic                               w_div_start;
    logic                               w_div_done;
    logic [ctb_pkg::DELAY_W-1:0]        w_div_quo;
    logic [ctb_pkg::MS_W-1:0]           w_divisor;

    logic                               w_accept;
    logic [ctb_pkg::CALC_W-1:0]         w_q_ext;
    ctb_pkg::t_count                    w_count;
    logic                               w_free_found;
    logic [ctb_pkg::SLOT_W-1:0]         w_free_slot;
    ctb_pkg::t_count                    w_dec;
    logic [ctb_pkg::TPS_W:0]            w_sw_next;
    logic [ctb_pkg::TPS_W:0]            w_sw_limit;
    logic [ctb_pkg::MASK_W-1:0]         w_pending;

    assign busy        = (r_state != ctb_pkg::S_IDLE);
    assign w_accept    = start && !busy;
    assign o_cfg_ready = 1'b1;

    // ms_per_tick of zero divides by one
    assign w_divisor = (r_ms == '0) ? ctb_pkg::MS_W'(1) : r_ms;

    ctb_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (i_delay_ms),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // saturate the quotient to the count width
    assign w_q_ext = ctb_pkg::CALC_W'(w_div_quo);
    assign w_count = (w_q_ext > ctb_pkg::COUNT_MAX) ? '1
                                                    : ctb_pkg::COUNT_WIDTH'(w_q_ext);

    // lowest free slot
    always_comb begin
        w_free_found = 1'b0;
        w_free_slot  = '0;
        for (int i = ctb_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                w_free_found = 1'b1;
                w_free_slot  = ctb_pkg::SLOT_W'(i);
            end
        end
    end

    assign w_dec      = r_rd_data - ctb_pkg::COUNT_WIDTH'(1);
    assign w_sw_next  = {1'b0, r_sw_cnt} + (ctb_pkg::TPS_W + 1)'(1);
    // interval of zero means a full 256-tick wrap
    assign w_sw_limit = (r_tps == '0) ? (ctb_pkg::TPS_W + 1)'(1 << ctb_pkg::TPS_W)
                                      : {1'b0, r_tps};

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_busy      = r_busy;
        n_done      = r_done;
        n_sw_cnt    = r_sw_cnt;
        n_ms        = r_ms;
        n_tps       = r_tps;
        n_granted   = r_granted;
        n_gslot     = r_gslot;
        n_refused   = r_refused;
        n_at_once   = r_at_once;
        n_expired   = r_expired;
        n_sw        = r_sw;
        w_div_start = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_waddr = r_idx;
        w_mem_wdata = w_dec;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                ctb_pkg::CFG_MS_PER_TICK:      n_ms  = ctb_pkg::MS_W'(i_cfg_data);
                ctb_pkg::CFG_TICKS_PER_SWITCH: n_tps = ctb_pkg::TPS_W'(i_cfg_data);
                default: ;
            endcase
        end

        case (r_state)
            ctb_pkg::S_IDLE: begin
                if (start) begin
                    n_granted = 1'b0;
                    n_gslot   = '0;
                    n_refused = 1'b0;
                    n_at_once = 1'b0;
                    n_expired = '0;
                    n_sw      = 1'b0;
                    case (ctb_pkg::t_mode'(i_mode))
                        ctb_pkg::MODE_TICK: begin
                            if (w_sw_next >= w_sw_limit) begin
                                n_sw     = 1'b1;
                                n_sw_cnt = '0;
                            end else begin
                                n_sw_cnt = ctb_pkg::TPS_W'(w_sw_next);
                            end
                            n_idx   = '0;
                            n_state = ctb_pkg::S_TICK_RD;
                        end
                        ctb_pkg::MODE_REQUEST: begin
                            w_div_start = 1'b1;
                            n_state     = ctb_pkg::S_DIV;
                        end
                        ctb_pkg::MODE_ACK: begin
                            // slots beyond the bank are ignored
                            for (int i = 0; i < ctb_pkg::SLOT_COUNT; i++) begin
                                if (32'(i_ack_slot) == i) n_done[i] = 1'b0;
                            end
                            n_state = ctb_pkg::S_RESP;
                        end
                        default: n_state = ctb_pkg::S_RESP;
                    endcase
                end
            end
            ctb_pkg::S_TICK_RD: begin
                n_state = ctb_pkg::S_TICK_WR;
            end
            ctb_pkg::S_TICK_WR: begin
                if (r_busy[r_idx]) begin
                    w_mem_we = 1'b1;
                    if (w_dec == '0) begin
                        n_busy[r_idx] = 1'b0;
                        n_done[r_idx] = 1'b1;
                        for (int i = 0; i < ctb_pkg::VIS_SLOTS; i++) begin
                            if (r_idx == ctb_pkg::SLOT_W'(i)) n_expired[i] = 1'b1;
                        end
                    end
                end
                if (r_idx == ctb_pkg::SLOT_W'(ctb_pkg::SLOT_COUNT - 1)) begin
                    n_state = ctb_pkg::S_RESP;
                end else begin
                    n_idx   = r_idx + ctb_pkg::SLOT_W'(1);
                    n_state = ctb_pkg::S_TICK_RD;
                end
            end
            ctb_pkg::S_DIV: begin
                if (w_div_done) begin
                    if (w_count == '0) begin
                        // rounds to zero: done at once, no slot used
                        n_at_once = 1'b1;
                    end else if (w_free_found) begin
                        w_mem_we             = 1'b1;
                        w_mem_waddr          = w_free_slot;
                        w_mem_wdata          = w_count;
                        n_busy[w_free_slot]  = 1'b1;
                        n_done[w_free_slot]  = 1'b0;   // stale flag goes away
                        n_granted            = 1'b1;
                        n_gslot              = w_free_slot;
                    end else begin
                        n_refused = 1'b1;
                    end
                    n_state = ctb_pkg::S_RESP;
                end
            end
            ctb_pkg::S_RESP: begin
                n_state = ctb_pkg::S_IDLE;
            end
            default: n_state = ctb_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ctb_pkg::S_IDLE;
            r_idx    <= '0;
            r_busy   <= '0;
            r_done   <= '0;
            r_sw_cnt <= '0;
            r_ms     <= ctb_pkg::MS_RESET;
            r_tps    <= ctb_pkg::TPS_RESET;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_busy   <= n_busy;
            r_done   <= n_done;
            r_sw_cnt <= n_sw_cnt;
            r_ms     <= n_ms;
            r_tps    <= n_tps;
        end
        r_granted <= n_granted;
        r_gslot   <= n_gslot;
        r_refused <= n_refused;
        r_at_once <= n_at_once;
        r_expired <= n_expired;
        r_sw      <= n_sw;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) mem[w_mem_waddr] <= w_mem_wdata;
        r_rd_data <= mem[r_idx];
    end

    always_comb begin
        w_pending = '0;
        for (int i = 0; i < ctb_pkg::VIS_SLOTS; i++) begin
            w_pending[i] = r_done[i];
        end
    end

    assign o_result_valid = (r_state == ctb_pkg::S_RESP);
    assign o_granted      = r_granted;
    assign o_granted_slot = ctb_pkg::OUT_SLOT_W'(r_gslot);
    assign o_refused      = r_refused;
    assign o_done_at_once = r_at_once;
    assign o_expired_now  = r_expired;
    assign o_pending_done = w_pending;
    assign o_switch_due   = r_sw;

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("accepted command did not raise busy");

    a_result_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !busy)
        else $error("busy held after result cycle");

    a_outcome_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !(o_granted && o_refused) &&
                           !(o_done_at_once && (o_granted || o_refused)))
        else $error("request reported more than one outcome");

    a_expired_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ((o_expired_now & ~o_pending_done) == '0))
        else $error("expired slot without pending done flag");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ctb_pkg::S_DIV))
        else $error("divider finished outside of a request");

endmodule

// ===== rtl/ctb_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module ctb_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ctb_pkg::DELAY_W-1:0]   i_dividend,
    input  logic [ctb_pkg::MS_W-1:0]      i_divisor,
    output logic                          o_done,
    output logic [ctb_pkg::DELAY_W-1:0]   o_quotient
);

    logic                            r_run;
    logic                            r_done;
    logic [ctb_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [ctb_pkg::MS_W-1:0]        r_div;
    logic [ctb_pkg::MS_W-1:0]        r_rem;
    logic [ctb_pkg::DELAY_W-1:0]     r_quo;

    logic                            n_run;
    logic                            n_done;
    logic [ctb_pkg::DIV_CNT_W-1:0]   n_cnt;
    logic [ctb_pkg::MS_W-1:0]        n_div;
    logic [ctb_pkg::MS_W-1:0]        n_rem;
    logic [ctb_pkg::DELAY_W-1:0]     n_quo;

    logic [ctb_pkg::MS_W:0]          w_trial;
    logic                            w_fits;

    assign w_trial = {r_rem, r_quo[ctb_pkg::DELAY_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_div});

    always_comb begin
        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_div  = r_div;
        n_rem  = r_rem;
        n_quo  = r_quo;
        if (i_start) begin
            n_run = 1'b1;
            n_cnt = '0;
            n_div = i_divisor;
            n_rem = '0;
            n_quo = i_dividend;
        end else if (r_run) begin
            n_rem = w_fits ? ctb_pkg::MS_W'(w_trial - {1'b0, r_div})
                           : ctb_pkg::MS_W'(w_trial);
            n_quo = {r_quo[ctb_pkg::DELAY_W-2:0], w_fits};
            n_cnt = r_cnt + ctb_pkg::DIV_CNT_W'(1);
            if (r_cnt == ctb_pkg::DIV_CNT_W'(ctb_pkg::DELAY_W - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_div <= n_div;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
